FILE: rtl/bse_pkg.sv
// Package for the bubble sort engine: data width and sequencer state type.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package bse_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PRIME,
        S_LOADC,
        S_STEP,
        S_FLUSH,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/bse_if.sv
// Valid/ready channel interfaces for the bubble sort engine input and output.
// Depends on bse_pkg for the data type.
`default_nettype none

interface bse_in_if;
    logic               valid;
    logic               ready;
    bse_pkg::t_data     value;
    logic               last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface bse_out_if;
    logic               valid;
    logic               ready;
    bse_pkg::t_data     sorted_value;
    logic               end_of_run;
    logic               overflowed;

    modport source (output valid, output sorted_value, output end_of_run,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_run,
                    input overflowed, output ready);
endinterface

`default_nettype wire

FILE: rtl/bubble_sort_engine.sv
// Bubble sort engine: loads one value per cycle, sorts with one shared compare
// unit streaming over a single-port-write memory, then emits in ascending order.
// After the last request it makes one pass per length m = n..2, then reads each result
// out through S_OUT_RD and S_OUT_LD, holding under output stall. Ready only while loading.
// Synchronous active-low reset clears count, overflow flag, state and out valid.
// Depends on bse_pkg and bse_if.
`default_nettype none

module bubble_sort_engine #(
    parameter int MAX_ITEMS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bse_in_if.sink      i_in,
    bse_out_if.source   o_out
);
    import bse_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_TWO = CW'(2);

    t_data          mem [MAX_ITEMS];

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic           r_dropped, n_dropped;
    logic [CW-1:0]  r_m, n_m;
    logic [CW-1:0]  r_k, n_k;
    t_data          r_carry, n_carry;
    t_data          r_rd_data;
    logic           r_out_valid, n_out_valid;
    t_data          r_out_value, n_out_value;
    logic           r_out_end, n_out_end;
    logic           r_out_ovf, n_out_ovf;

    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    t_data          mem_wd;
    logic [AW-1:0]  mem_ra;
    logic           in_acc;
    logic           out_free;
    logic [CW-1:0]  k_inc;
    logic [CW-1:0]  m_dec;

    assign in_acc   = i_in.valid && (r_state == S_LOAD);
    assign out_free = !r_out_valid || o_out.ready;
    assign k_inc    = r_k + CNT_ONE;
    assign m_dec    = r_m - CNT_ONE;

    assign i_in.ready         = (r_state == S_LOAD);
    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.end_of_run   = r_out_end;
    assign o_out.overflowed   = r_out_ovf;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && i_in.last_item) begin
                    if (n_count >= CNT_TWO) n_state = S_PRIME;
                    else                    n_state = S_OUT_RD;
                end
            end
            S_PRIME:  n_state = S_LOADC;
            S_LOADC:  n_state = S_STEP;
            S_STEP: begin
                if (k_inc == r_m) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (m_dec >= CNT_TWO) n_state = S_PRIME;
                else                  n_state = S_OUT_RD;
            end
            S_OUT_RD: n_state = S_OUT_LD;
            S_OUT_LD: begin
                if (out_free) begin
                    if (k_inc == r_count) n_state = S_LOAD;
                    else                  n_state = S_OUT_RD;
                end
            end
            default:  n_state = S_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_m         = r_m;
        n_k         = r_k;
        n_carry     = r_carry;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_value = r_out_value;
        n_out_end   = r_out_end;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_wa      = r_count[AW-1:0];
        mem_wd      = i_in.value;
        mem_ra      = r_k[AW-1:0];
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count < CNT_MAX) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CNT_ONE;
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
                n_m = n_count;
                n_k = '0;
            end
            S_PRIME: begin
                mem_ra = '0;
            end
            S_LOADC: begin
                n_carry = r_rd_data;
                mem_ra  = AW'(1);
                n_k     = CNT_ONE;
            end
            S_STEP: begin
                // carry the larger value forward, drop the smaller one behind
                mem_ra = k_inc[AW-1:0];
                mem_we = 1'b1;
                mem_wa = AW'(r_k - CNT_ONE);
                if (r_carry > r_rd_data) begin
                    mem_wd = r_rd_data;
                end else begin
                    mem_wd  = r_carry;
                    n_carry = r_rd_data;
                end
                n_k = k_inc;
            end
            S_FLUSH: begin
                mem_we = 1'b1;
                mem_wa = m_dec[AW-1:0];
                mem_wd = r_carry;
                n_m    = m_dec;
                n_k    = '0;
            end
            S_OUT_RD: begin
                mem_ra = r_k[AW-1:0];
            end
            S_OUT_LD: begin
                mem_ra = r_k[AW-1:0];
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_rd_data;
                    n_out_end   = (k_inc == r_count);
                    n_out_ovf   = r_dropped;
                    n_k         = k_inc;
                    if (k_inc == r_count) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m         <= n_m;
        r_k         <= n_k;
        r_carry     <= n_carry;
        r_out_value <= n_out_value;
        r_out_end   <= n_out_end;
        r_out_ovf   <= n_out_ovf;
    end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for bubble_sort_engine: streams runs of signed values, predicts
// the sorted output of each run with a scoreboard class, and checks every result in order.
// Depends on bse_pkg and the bse_in_if / bse_out_if channel interfaces.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bse_pkg::*;

    localparam int    CAPACITY     = 64;
    localparam int    ITEMS_TARGET = 480;
    localparam int    LIMIT_CYCLES = 400000;
    localparam int    HOLD_CYCLES  = 3000;
    localparam int    DRAIN_CYCLES = 200;
    localparam t_data T_MAX        = t_data'(32'h7fff_ffff);
    localparam t_data T_MIN        = t_data'(32'h8000_0000);

    typedef struct {
        t_data value;
        bit    end_of_run;
        bit    overflowed;
    } t_sorted_entry;

    // Collects the values of the current run and queues its sorted results on the last request.
    class sorted_run_board;
        t_data         run_values[$];
        bit            run_dropped;
        t_sorted_entry pending_sorted[$];
        int            mismatches;
        int            results_seen;
        int            runs_seen;

        function void note_request(t_data value, bit last_item);
            t_data         tmp;
            int            n;
            t_sorted_entry entry;
            if (run_values.size() < CAPACITY) begin
                run_values.push_back(value);
            end else begin
                run_dropped = 1'b1;
            end
            if (!last_item) return;
            n = run_values.size();
            for (int i = 0; i + 1 < n; i++) begin
                for (int j = 0; j + 1 < n - i; j++) begin
                    if (run_values[j] > run_values[j + 1]) begin
                        tmp               = run_values[j];
                        run_values[j]     = run_values[j + 1];
                        run_values[j + 1] = tmp;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                entry.value      = run_values[k];
                entry.end_of_run = (k == n - 1);
                entry.overflowed = run_dropped;
                pending_sorted.push_back(entry);
            end
            run_values.delete();
            run_dropped = 1'b0;
            runs_seen++;
        endfunction

        function void check_result(t_data got_value, logic got_end, logic got_ovf);
            t_sorted_entry want;
            results_seen++;
            if (pending_sorted.size() == 0) begin
                $display("%0t: unexpected result sorted_value=%0d end_of_run=%b overflowed=%b",
                         $time, got_value, got_end, got_ovf);
                mismatches++;
                return;
            end
            want = pending_sorted.pop_front();
            if (got_value !== want.value) begin
                $display("%0t: sorted_value mismatch expected %0d actual %0d",
                         $time, want.value, got_value);
                mismatches++;
            end
            if (got_end !== want.end_of_run) begin
                $display("%0t: end_of_run mismatch expected %b actual %b",
                         $time, want.end_of_run, got_end);
                mismatches++;
            end
            if (got_ovf !== want.overflowed) begin
                $display("%0t: overflowed mismatch expected %b actual %b",
                         $time, want.overflowed, got_ovf);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bse_in_if  in_ch ();
    bse_out_if out_ch ();

    sorted_run_board board = new;

    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_request;
    int items_sent;
    int longest_run;
    int holds_done;
    int cycles;

    bubble_sort_engine #(
        .MAX_ITEMS (CAPACITY)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("%0t: timeout after %0d cycles", $time, cycles);
                $display("bubble_sort_engine verification failed");
                $finish;
            end
        end
    end

    // Hold the request until the block takes it; valid stays high for back-to-back requests.
    task automatic send_request(input t_data value, input bit last_item);
        in_ch.valid     <= 1'b1;
        in_ch.value     <= value;
        in_ch.last_item <= last_item;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        board.note_request(value, last_item);
        items_sent++;
    endtask

    task automatic sender_gap();
        int gap;
        if (!tx_idle_on || $urandom_range(0, 9) < 6) return;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        if (board.pending_sorted.size() == 0) return;
        in_ch.valid <= 1'b0;
        while (board.pending_sorted.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_data pick_value();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12) return t_data'($urandom);
        if (sel < 17) return t_data'(int'($urandom_range(0, 16)) - 8);
        case ($urandom_range(0, 3))
            0: return T_MIN;
            1: return T_MAX;
            2: return t_data'(-1);
            default: return t_data'(0);
        endcase
    endfunction

    task automatic send_run(input int size);
        for (int k = 0; k < size; k++) begin
            send_request(pick_value(), k == size - 1);
            sender_gap();
        end
        if (size > longest_run) longest_run = size;
    endtask

    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                    : $urandom_range(1, 3);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                board.check_result(out_ch.sorted_value, out_ch.end_of_run, out_ch.overflowed);
            end
        end
    end

    initial begin : stimulus
        int size;
        int run_index;
        int failures;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.value     <= '0;
        in_ch.last_item <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-value runs at both extremes
        send_request(T_MAX, 1'b1);
        send_request(T_MIN, 1'b1);
        // Mixed extremes around zero
        send_request(t_data'(0), 1'b0);
        send_request(t_data'(-1), 1'b0);
        send_request(T_MAX, 1'b0);
        send_request(T_MIN, 1'b0);
        send_request(t_data'(1), 1'b0);
        send_request(t_data'(-2), 1'b1);
        // Equal values must stay put
        send_request(t_data'(7), 1'b0);
        send_request(t_data'(7), 1'b0);
        send_request(t_data'(-7), 1'b0);
        send_request(t_data'(7), 1'b1);
        // Descending, then already ascending
        send_request(t_data'(400), 1'b0);
        send_request(t_data'(300), 1'b0);
        send_request(t_data'(-100), 1'b0);
        send_request(T_MIN, 1'b1);
        send_request(T_MIN, 1'b0);
        send_request(t_data'(-3), 1'b0);
        send_request(t_data'(0), 1'b0);
        send_request(T_MAX, 1'b1);

        run_index = 0;
        while (items_sent < ITEMS_TARGET) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            case (run_index)
                3:       size = CAPACITY;
                9:       size = CAPACITY + 1;
                15:      size = CAPACITY + 6;
                default: size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                            : $urandom_range(1, 12);
            endcase
            if (run_index % 7 == 4) wait_drained();
            if (run_index == 6) begin
                // Stall the output for a long stretch while requests keep coming
                wait_drained();
                rx_hold_request = 1'b1;
                tx_idle_on      = 1'b0;
            end
            send_run(size);
            run_index++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        failures = board.mismatches + board.pending_sorted.size();
        $display("covered %0d requests in %0d runs (longest %0d, overflow runs included)",
                 items_sent, board.runs_seen, longest_run);
        $display("checked %0d sorted results, %0d long output holds, %0d cycles",
                 board.results_seen, holds_done, cycles);
        if (failures == 0) begin
            $display("bubble_sort_engine verification clean");
        end else begin
            $display("bubble_sort_engine verification failed");
        end
        $finish;
    end

endmodule
